// ===== sv/sel_pkg.sv =====
// ----------------------------------------------------------------------------
// sel_pkg
// Types and constants shared by the S-expression byte lexer modules.
// ----------------------------------------------------------------------------
package sel_pkg;

  // Input kind codes
  localparam logic KIND_BYTE = 1'b0;
  localparam logic KIND_EOT  = 1'b1;

  // Token classes
  localparam logic [1:0] CLASS_ATOM  = 2'd0;
  localparam logic [1:0] CLASS_STR   = 2'd1;
  localparam logic [1:0] CLASS_PAREN = 2'd2;

  // Characters of interest
  localparam logic [7:0] CH_LPAREN = 8'h28;
  localparam logic [7:0] CH_RPAREN = 8'h29;
  localparam logic [7:0] CH_QUOTE  = 8'h22;
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_CR     = 8'h0D;

  // Job queue between front and back
  localparam int SEL_QDEPTH = 4;
  localparam int SEL_QAW    = $clog2(SEL_QDEPTH);

  // Lexer mode, one-hot
  typedef enum logic [3:0] {
    MODE_IDLE = 4'b0001,
    MODE_ATOM = 4'b0010,
    MODE_STR  = 4'b0100,
    MODE_ESC  = 4'b1000
  } mode_t;

  typedef struct packed {
    logic       kind;
    logic [7:0] text_byte;
  } in_item_t;

  typedef struct packed {
    logic [7:0] token_byte;
    logic       token_end;
    logic [1:0] token_class;
    logic       last_of_run;
  } out_item_t;

  // One result without its last-of-run flag
  typedef struct packed {
    logic [7:0] token_byte;
    logic       token_end;
    logic [1:0] token_class;
  } res_t;

  // All results of one input item; cnt is 1 to 3
  typedef struct packed {
    logic [1:0]       cnt;
    res_t [2:0]       res;
  } job_t;

  typedef struct packed {
    logic empty;
    logic full;
  } q_stat_t;

endpackage

// ===== sv/sel_front.sv =====
// ----------------------------------------------------------------------------
// sel_front
// Classifies each input item against the lexer mode and builds its job.
// ----------------------------------------------------------------------------
module sel_front
  import sel_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     accept,
  input  in_item_t item,
  output logic     push,
  output job_t     job
);

  mode_t mode_r, mode_nxt;

  always_comb begin
    logic [7:0] c;
    logic       is_blank, is_paren, is_quote, is_delim;
    logic [1:0] n;
    c        = item.text_byte;
    is_blank = ((c >= CH_TAB) && (c <= CH_CR)) || (c == CH_SPACE);
    is_paren = (c == CH_LPAREN) || (c == CH_RPAREN);
    is_quote = (c == CH_QUOTE);
    is_delim = is_blank || is_paren || is_quote;
    n        = 2'd0;
    job.res  = '0;
    mode_nxt = mode_r;
    if (item.kind == KIND_EOT) begin
      if (mode_r == MODE_ATOM) begin
        job.res[0] = '{8'd0, 1'b1, CLASS_ATOM};
        n = 2'd1;
      end else if (mode_r == MODE_STR || mode_r == MODE_ESC) begin
        job.res[0] = '{8'd0, 1'b1, CLASS_STR};
        n = 2'd1;
      end
      mode_nxt = MODE_IDLE;
    end else begin
      unique case (mode_r)
        MODE_ESC: begin
          job.res[0] = '{c, 1'b0, CLASS_STR};
          n = 2'd1;
          mode_nxt = MODE_STR;
        end
        MODE_STR: begin
          n = 2'd1;
          if (is_quote) begin
            job.res[0] = '{8'd0, 1'b1, CLASS_STR};
            mode_nxt = MODE_IDLE;
          end else begin
            job.res[0] = '{c, 1'b0, CLASS_STR};
            if (c == CH_BSLASH) mode_nxt = MODE_ESC;
          end
        end
        MODE_ATOM, MODE_IDLE: begin
          if (mode_r == MODE_ATOM && !is_delim) begin
            job.res[0] = '{c, 1'b0, CLASS_ATOM};
            n = 2'd1;
          end else begin
            // an open atom is closed before the delimiter is handled
            if (mode_r == MODE_ATOM) begin
              job.res[0] = '{8'd0, 1'b1, CLASS_ATOM};
              n = 2'd1;
            end
            mode_nxt = MODE_IDLE;
            if (is_blank) begin
              mode_nxt = MODE_IDLE;
            end else if (is_paren) begin
              job.res[n]         = '{c, 1'b0, CLASS_PAREN};
              job.res[n + 2'd1]  = '{8'd0, 1'b1, CLASS_PAREN};
              n = n + 2'd2;
            end else if (is_quote) begin
              mode_nxt = MODE_STR;
            end else begin
              job.res[n] = '{c, 1'b0, CLASS_ATOM};
              n = n + 2'd1;
              mode_nxt = MODE_ATOM;
            end
          end
        end
        default: begin
          mode_nxt = MODE_IDLE;
        end
      endcase
    end
    job.cnt = n;
    push    = accept && (n != 2'd0);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= MODE_IDLE;
    end else if (accept) begin
      mode_r <= mode_nxt;
    end
  end

`ifndef SYNTHESIS
  a_eot_idle: assert property (@(posedge clk) disable iff (!rst_n)
    accept && item.kind == KIND_EOT |=> mode_r == MODE_IDLE)
    else $error("mode not idle after end of text");
`endif

endmodule

// ===== sv/sel_fifo.sv =====
// ----------------------------------------------------------------------------
// sel_fifo
// Short job queue between the front and back parts of the lexer.
// ----------------------------------------------------------------------------
module sel_fifo
  import sel_pkg::*;
(
  input  logic    clk,
  input  logic    rst_n,
  input  logic    push,
  input  job_t    push_job,
  input  logic    pop,
  output job_t    head,
  output q_stat_t stat
);

  job_t               mem_r [SEL_QDEPTH];
  logic [SEL_QAW-1:0] wp_r, wp_nxt;
  logic [SEL_QAW-1:0] rp_r, rp_nxt;
  logic [SEL_QAW:0]   cnt_r, cnt_nxt;

  assign stat.empty = (cnt_r == '0);
  assign stat.full  = (cnt_r == (SEL_QAW+1)'(SEL_QDEPTH));
  assign head       = mem_r[rp_r];

  always_comb begin
    wp_nxt  = push ? wp_r + 1'b1 : wp_r;
    rp_nxt  = pop  ? rp_r + 1'b1 : rp_r;
    cnt_nxt = cnt_r + (SEL_QAW+1)'(push) - (SEL_QAW+1)'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) mem_r[wp_r] <= push_job;
  end

`ifndef SYNTHESIS
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    !(push && stat.full && !pop))
    else $error("job queue overflow");
  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    !(pop && stat.empty))
    else $error("job queue underflow");
`endif

endmodule

// ===== sv/sel_back.sv =====
// ----------------------------------------------------------------------------
// sel_back
// Unpacks queued jobs into single results behind an output register.
// ----------------------------------------------------------------------------
module sel_back
  import sel_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  job_t      head,
  input  q_stat_t   stat,
  output logic      pop,
  output logic      out_valid,
  output out_item_t out_item,
  input  logic      out_stall
);

  logic      valid_r, valid_nxt;
  out_item_t item_r, item_nxt;
  logic [1:0] idx_r, idx_nxt;
  logic      load, last;

  assign load = !valid_r || !out_stall;
  assign last = (idx_r == head.cnt - 2'd1);
  assign pop  = load && !stat.empty && last;

  always_comb begin
    valid_nxt = valid_r;
    item_nxt  = item_r;
    idx_nxt   = idx_r;
    if (load) begin
      valid_nxt = !stat.empty;
      if (!stat.empty) begin
        item_nxt = '{head.res[idx_r].token_byte, head.res[idx_r].token_end,
                     head.res[idx_r].token_class, last};
        idx_nxt  = last ? 2'd0 : idx_r + 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      idx_r   <= 2'd0;
    end else begin
      valid_r <= valid_nxt;
      idx_r   <= idx_nxt;
    end
  end

  always_ff @(posedge clk) begin
    item_r <= item_nxt;
  end

  assign out_valid = valid_r;
  assign out_item  = item_r;

`ifndef SYNTHESIS
  a_idx_in_job: assert property (@(posedge clk) disable iff (!rst_n)
    !stat.empty |-> (idx_r < head.cnt))
    else $error("result index beyond job");
`endif

endmodule

// ===== sv/s_expression_byte_lexer.sv =====
// An item's results are written into the job queue, then into the output register.
// Throughput: one input item per cycle unless the queue is full; the output side
//   gives one result per cycle while not stalled, one after another for an item's results.
// A four-entry job queue sets how far input may run ahead of the output side.
// Reset (rst_n low, synchronous): mode returns to between tokens, queue and
//   output register are emptied.
// ----------------------------------------------------------------------------
// s_expression_byte_lexer
// Streaming S-expression tokenizer: bytes in, token bytes and end markers out.
// ----------------------------------------------------------------------------
module s_expression_byte_lexer
  import sel_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  input  in_item_t  in_item,
  output logic      in_stall,
  output logic      out_valid,
  output out_item_t out_item,
  input  logic      out_stall
);

  logic    accept;
  logic    push;
  logic    pop;
  job_t    job;
  job_t    head;
  q_stat_t stat;

  // Input is held off only by a full queue; stall comes straight from a
  // register-derived flag, so it never depends on in_valid.
  assign in_stall = stat.full;
  assign accept   = in_valid && !in_stall;

  // Front: mode tracking and classification; items with no results
  // (whitespace or end of text with no open token, opening quote with no open atom) push nothing.
  sel_front u_front (
    .clk    (clk),
    .rst_n  (rst_n),
    .accept (accept),
    .item   (in_item),
    .push   (push),
    .job    (job)
  );

  // Queue of jobs, each holding up to three ready-made results.
  sel_fifo u_fifo (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_job (job),
    .pop      (pop),
    .head     (head),
    .stat     (stat)
  );

  // Back: walks the head job one result per cycle, while the output is not stalled, into the output register.
  sel_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .head      (head),
    .stat      (stat),
    .pop       (pop),
    .out_valid (out_valid),
    .out_item  (out_item),
    .out_stall (out_stall)
  );

endmodule
